### hdl/interrupt_controller_two_context_defines.svh
// Assertion helpers shared by the controller and the datapath.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef INTERRUPT_CONTROLLER_TWO_CONTEXT_DEFINES_SVH
`define INTERRUPT_CONTROLLER_TWO_CONTEXT_DEFINES_SVH

// Same-cycle implication.
`define ICTC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ICTC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ictc_pkg.sv
`timescale 1ns / 1ps
package ictc_pkg;

   localparam int SRC_W       = 5;
   localparam int NUM_SLOTS   = 32;
   localparam int PRIO_W      = 3;
   localparam int OFF_W       = 22;
   localparam int DATA_W      = 32;
   localparam int OWNER_W     = 2;
   localparam int SOURCES_DEF = 31;

   // Register map, byte offsets
   localparam logic [OFF_W-1:0] PENDING_OFF  = 22'h001000;
   localparam logic [OFF_W-1:0] M_ENABLE_OFF = 22'h002000;
   localparam logic [OFF_W-1:0] S_ENABLE_OFF = 22'h002080;
   localparam logic [OFF_W-1:0] M_THRESH_OFF = 22'h200000;
   localparam logic [OFF_W-1:0] S_THRESH_OFF = 22'h201000;
   localparam logic [OFF_W-1:0] M_CLAIM_OFF  = 22'h200004;
   localparam logic [OFF_W-1:0] S_CLAIM_OFF  = 22'h201004;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_LEVEL = 2'd2
   } command_type;

   typedef enum logic [OWNER_W-1:0] {
      OWNER_NONE = 2'd0,
      OWNER_M    = 2'd1,
      OWNER_S    = 2'd2
   } owner_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRESCAN,
      ST_EXEC,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_clear;
      logic scan_step;
      logic exec;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic claim_read;
      logic scan_last;
   } dp_stat_type;

endpackage

### hdl/interrupt_controller_two_context.sv
`timescale 1ns / 1ps
// Interrupt controller for one hart with a machine and a supervisor context.
// Request channel (req_*): one beat is a register read, a register write or a
// level change of one source. Result channel (rsp_*): exactly one beat per
// request, carrying read data, the access error flag and both interrupt lines
// as they stand after the request.
// A beat moves when valid is high and stall is low on that channel.
// An accepted request first walks the sources to pick the winner, but only
// for a read of a claim register; it then executes, a second walk over the
// sources updates both interrupt lines, and the result then enters the output
// register. Each walk looks at one source per cycle through the single
// priority read port. One request is in work at a time; req_stall is high
// from acceptance until its result enters the output register.
// Synchronous reset clears all priorities, pending, level and claim state, the
// enables and thresholds, and drops rsp_valid.
// While the receiver stalls, the result beat holds in the output register; the
// next request may be accepted meanwhile but its result waits behind it.
module interrupt_controller_two_context #(
   parameter int SOURCES = ictc_pkg::SOURCES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_command,
   input  logic [ictc_pkg::OFF_W-1:0]  req_offset,
   input  logic                        req_word_access,
   input  logic [ictc_pkg::DATA_W-1:0] req_write_data,
   input  logic [ictc_pkg::SRC_W-1:0]  req_source_id,
   input  logic                        req_source_level,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ictc_pkg::DATA_W-1:0] rsp_read_data,
   output logic                        rsp_access_error,
   output logic                        rsp_machine_irq,
   output logic                        rsp_supervisor_irq
);

   ictc_pkg::ctl_cmd_type ctl_cmd;
   ictc_pkg::dp_stat_type dp_stat;

   ictc_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl_cmd   (ctl_cmd),
      .dp_stat   (dp_stat)
   );

   ictc_dp #(
      .SOURCES (SOURCES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl_cmd            (ctl_cmd),
      .dp_stat            (dp_stat),
      .req_command        (req_command),
      .req_offset         (req_offset),
      .req_word_access    (req_word_access),
      .req_write_data     (req_write_data),
      .req_source_id      (req_source_id),
      .req_source_level   (req_source_level),
      .rsp_read_data      (rsp_read_data),
      .rsp_access_error   (rsp_access_error),
      .rsp_machine_irq    (rsp_machine_irq),
      .rsp_supervisor_irq (rsp_supervisor_irq)
   );

endmodule

### hdl/ictc_ctl.sv
`timescale 1ns / 1ps
`include "interrupt_controller_two_context_defines.svh"
module ictc_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ictc_pkg::ctl_cmd_type ctl_cmd,
   input  ictc_pkg::dp_stat_type dp_stat
);

   ictc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ictc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      unique case (state_ff)
         ictc_pkg::ST_IDLE: begin
            if (req_valid) begin
               ctl_cmd.accept     = 1'b1;
               ctl_cmd.scan_clear = 1'b1;
               state_in           = ictc_pkg::ST_PRESCAN;
            end
         end
         ictc_pkg::ST_PRESCAN: begin
            // only a claim read needs the selection before it executes
            if (!dp_stat.claim_read) begin
               state_in = ictc_pkg::ST_EXEC;
            end else begin
               ctl_cmd.scan_step = 1'b1;
               if (dp_stat.scan_last) state_in = ictc_pkg::ST_EXEC;
            end
         end
         ictc_pkg::ST_EXEC: begin
            ctl_cmd.exec       = 1'b1;
            ctl_cmd.scan_clear = 1'b1;
            state_in           = ictc_pkg::ST_SCAN;
         end
         ictc_pkg::ST_SCAN: begin
            ctl_cmd.scan_step = 1'b1;
            if (dp_stat.scan_last) state_in = ictc_pkg::ST_EMIT;
         end
         ictc_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl_cmd.load_out = 1'b1;
               state_in         = ictc_pkg::ST_IDLE;
            end
         end
         default: state_in = ictc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (ctl_cmd.load_out) rsp_valid_in = 1'b1;
      else if (!rsp_stall)  rsp_valid_in = 1'b0;
      else                  rsp_valid_in = rsp_valid_ff;
   end

   assign req_stall = (state_ff != ictc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ICTC_ASSERT_NXT(a_load_shows_beat, ctl_cmd.load_out, rsp_valid_ff, "result beat not presented")
   `ICTC_ASSERT_NXT(a_scan_runs_out,
      (state_ff == ictc_pkg::ST_SCAN) && !dp_stat.scan_last,
      state_ff == ictc_pkg::ST_SCAN, "scan left early")
   `ICTC_ASSERT_NXT(a_accept_holds_off, ctl_cmd.accept, req_stall, "input not held off")

endmodule

### hdl/ictc_dp.sv
`timescale 1ns / 1ps
`include "interrupt_controller_two_context_defines.svh"
module ictc_dp #(
   parameter int SOURCES = ictc_pkg::SOURCES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ictc_pkg::ctl_cmd_type             ctl_cmd,
   output ictc_pkg::dp_stat_type             dp_stat,
   input  logic [1:0]                        req_command,
   input  logic [ictc_pkg::OFF_W-1:0]        req_offset,
   input  logic                              req_word_access,
   input  logic [ictc_pkg::DATA_W-1:0]       req_write_data,
   input  logic [ictc_pkg::SRC_W-1:0]        req_source_id,
   input  logic                              req_source_level,
   output logic [ictc_pkg::DATA_W-1:0]       rsp_read_data,
   output logic                              rsp_access_error,
   output logic                              rsp_machine_irq,
   output logic                              rsp_supervisor_irq
);

   localparam int SRC_W   = ictc_pkg::SRC_W;
   localparam int PRIO_W  = ictc_pkg::PRIO_W;
   localparam int DATA_W  = ictc_pkg::DATA_W;
   localparam int OFF_W   = ictc_pkg::OFF_W;
   localparam int NSLOT   = ictc_pkg::NUM_SLOTS;
   localparam int PRIO_HI = SRC_W + 2;
   localparam logic [SRC_W-1:0] LAST_SRC = SRC_W'(SOURCES);

   // latched request beat
   logic [1:0]        op_ff;
   logic [OFF_W-1:0]  off_ff;
   logic              word_ff;
   logic [DATA_W-1:0] data_ff;
   logic [SRC_W-1:0]  src_ff;
   logic              lvl_ff;

   // controller state
   logic [PRIO_W-1:0]           prio_ff [NSLOT];
   logic [NSLOT-1:0]            pending_ff;
   logic [NSLOT-1:0]            level_ff;
   ictc_pkg::owner_type         owner_ff [NSLOT];
   logic [DATA_W-1:0]           enable_ff [2];
   logic [PRIO_W-1:0]           thr_ff [2];

   // selection scan
   logic [SRC_W-1:0]  idx_ff;
   logic [1:0]        found_ff;
   logic [SRC_W-1:0]  best_id_ff [2];
   logic [PRIO_W-1:0] best_prio_ff [2];

   // result held until the output register frees
   logic [DATA_W-1:0] res_data_ff;
   logic              res_err_ff;

   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_err_ff, rsp_mirq_ff, rsp_sirq_ff;

   // decode
   logic              bad, is_rw, prio_hit, claim_hit, ctx_s, compl_ok, src_ok;
   logic [SRC_W-1:0]  compl_id, sel_idx;
   logic [PRIO_W-1:0] sel_prio;
   ictc_pkg::owner_type sel_owner, ctx_owner;
   logic              sel_pend, sel_level;
   logic [1:0]        take;

   // exec effects
   logic [DATA_W-1:0] rdata_c;
   logic              err_c;
   logic              prio_we, pend_we, pend_wd, level_we, owner_we;
   ictc_pkg::owner_type owner_wd;
   logic [1:0]        en_we, thr_we;

   assign bad   = !word_ff || (off_ff[1:0] != 2'b00);
   assign is_rw = (op_ff == ictc_pkg::CMD_READ) || (op_ff == ictc_pkg::CMD_WRITE);
   assign prio_hit = (off_ff[OFF_W-1:PRIO_HI] == '0) && (off_ff[PRIO_HI-1:2] != '0)
                     && (off_ff[PRIO_HI-1:2] <= LAST_SRC);
   assign claim_hit = (off_ff == ictc_pkg::M_CLAIM_OFF) || (off_ff == ictc_pkg::S_CLAIM_OFF);
   assign ctx_s     = (off_ff == ictc_pkg::S_CLAIM_OFF);
   assign ctx_owner = ctx_s ? ictc_pkg::OWNER_S : ictc_pkg::OWNER_M;
   assign compl_id  = data_ff[SRC_W-1:0];
   assign compl_ok  = (data_ff[DATA_W-1:SRC_W] == '0) && (compl_id != '0)
                      && (compl_id <= LAST_SRC);
   assign src_ok    = (src_ff != '0) && (src_ff <= LAST_SRC);

   assign dp_stat.claim_read = (op_ff == ictc_pkg::CMD_READ) && !bad && claim_hit;
   assign dp_stat.scan_last  = (idx_ff == LAST_SRC);

   // one source slot is looked at per cycle
   always_comb begin
      if (!ctl_cmd.exec)                     sel_idx = idx_ff;
      else if (op_ff == ictc_pkg::CMD_LEVEL) sel_idx = src_ff;
      else if (claim_hit && op_ff == ictc_pkg::CMD_READ)
         sel_idx = best_id_ff[ctx_s];
      else if (claim_hit)                    sel_idx = compl_id;
      else                                   sel_idx = off_ff[PRIO_HI-1:2];
   end

   assign sel_prio  = prio_ff[sel_idx];
   assign sel_owner = owner_ff[sel_idx];
   assign sel_pend  = pending_ff[sel_idx];
   assign sel_level = level_ff[sel_idx];

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         take[c] = sel_pend && (sel_owner == ictc_pkg::OWNER_NONE)
                   && enable_ff[c][idx_ff] && (sel_prio > thr_ff[c])
                   && (!found_ff[c] || (sel_prio > best_prio_ff[c]));
      end
   end

   always_comb begin
      rdata_c  = '0;
      err_c    = 1'b0;
      prio_we  = 1'b0;
      pend_we  = 1'b0;
      pend_wd  = 1'b0;
      level_we = 1'b0;
      owner_we = 1'b0;
      owner_wd = ictc_pkg::OWNER_NONE;
      en_we    = '0;
      thr_we   = '0;
      if (is_rw && bad) begin
         err_c = 1'b1;
      end else if (op_ff == ictc_pkg::CMD_READ) begin
         if (prio_hit)
            rdata_c = {{(DATA_W-PRIO_W){1'b0}}, sel_prio};
         else if (off_ff == ictc_pkg::PENDING_OFF)
            rdata_c = pending_ff;
         else if (off_ff == ictc_pkg::M_ENABLE_OFF)
            rdata_c = enable_ff[0];
         else if (off_ff == ictc_pkg::S_ENABLE_OFF)
            rdata_c = enable_ff[1];
         else if (off_ff == ictc_pkg::M_THRESH_OFF)
            rdata_c = {{(DATA_W-PRIO_W){1'b0}}, thr_ff[0]};
         else if (off_ff == ictc_pkg::S_THRESH_OFF)
            rdata_c = {{(DATA_W-PRIO_W){1'b0}}, thr_ff[1]};
         else if (claim_hit && found_ff[ctx_s]) begin
            rdata_c  = {{(DATA_W-SRC_W){1'b0}}, best_id_ff[ctx_s]};
            pend_we  = 1'b1;
            owner_we = 1'b1;
            owner_wd = ctx_owner;
         end
      end else if (op_ff == ictc_pkg::CMD_WRITE) begin
         if (prio_hit)
            prio_we = 1'b1;
         else if (off_ff == ictc_pkg::M_ENABLE_OFF)
            en_we[0] = 1'b1;
         else if (off_ff == ictc_pkg::S_ENABLE_OFF)
            en_we[1] = 1'b1;
         else if (off_ff == ictc_pkg::M_THRESH_OFF)
            thr_we[0] = 1'b1;
         else if (off_ff == ictc_pkg::S_THRESH_OFF)
            thr_we[1] = 1'b1;
         else if (claim_hit && compl_ok && sel_owner == ctx_owner) begin
            // release and re-latch the level
            owner_we = 1'b1;
            pend_we  = 1'b1;
            pend_wd  = sel_level;
         end
      end else if (op_ff == ictc_pkg::CMD_LEVEL && src_ok) begin
         level_we = 1'b1;
         if (lvl_ff && sel_owner == ictc_pkg::OWNER_NONE) begin
            pend_we = 1'b1;
            pend_wd = 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl_cmd.accept) begin
         op_ff   <= req_command;
         off_ff  <= req_offset;
         word_ff <= req_word_access;
         data_ff <= req_write_data;
         src_ff  <= req_source_id;
         lvl_ff  <= req_source_level;
      end
      if (ctl_cmd.exec) begin
         res_data_ff <= rdata_c;
         res_err_ff  <= err_c;
      end
      if (ctl_cmd.load_out) begin
         rsp_data_ff <= res_data_ff;
         rsp_err_ff  <= res_err_ff;
         rsp_mirq_ff <= found_ff[0];
         rsp_sirq_ff <= found_ff[1];
      end
      if (ctl_cmd.scan_step) begin
         for (int c = 0; c < 2; c++) begin
            if (take[c]) begin
               best_id_ff[c]   <= idx_ff;
               best_prio_ff[c] <= sel_prio;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSLOT; i++) begin
            prio_ff[i]  <= '0;
            owner_ff[i] <= ictc_pkg::OWNER_NONE;
         end
         pending_ff <= '0;
         level_ff   <= '0;
         enable_ff[0] <= '0;
         enable_ff[1] <= '0;
         thr_ff[0]  <= '0;
         thr_ff[1]  <= '0;
         idx_ff     <= '0;
         found_ff   <= '0;
      end else begin
         if (ctl_cmd.exec) begin
            if (prio_we)  prio_ff[sel_idx]    <= data_ff[PRIO_W-1:0];
            if (pend_we)  pending_ff[sel_idx] <= pend_wd;
            if (level_we) level_ff[sel_idx]   <= lvl_ff;
            if (owner_we) owner_ff[sel_idx]   <= owner_wd;
            for (int c = 0; c < 2; c++) begin
               if (en_we[c])  enable_ff[c] <= {data_ff[DATA_W-1:1], 1'b0};
               if (thr_we[c]) thr_ff[c]    <= data_ff[PRIO_W-1:0];
            end
         end
         if (ctl_cmd.scan_clear) begin
            idx_ff   <= SRC_W'(1);
            found_ff <= '0;
         end else if (ctl_cmd.scan_step) begin
            idx_ff   <= idx_ff + SRC_W'(1);
            found_ff <= found_ff | take;
         end
      end
   end

   assign rsp_read_data      = rsp_data_ff;
   assign rsp_access_error   = rsp_err_ff;
   assign rsp_machine_irq    = rsp_mirq_ff;
   assign rsp_supervisor_irq = rsp_sirq_ff;

   logic [NSLOT-1:0] claimed;
   always_comb begin
      for (int i = 0; i < NSLOT; i++) claimed[i] = (owner_ff[i] != ictc_pkg::OWNER_NONE);
   end

   `ICTC_ASSERT_IMP(a_pend_not_claimed, 1'b1, (pending_ff & claimed) == '0,
      "source both pending and claimed")
   `ICTC_ASSERT_IMP(a_slot0_idle, 1'b1, !pending_ff[0] && !claimed[0],
      "source zero became active")
   `ICTC_ASSERT_NXT(a_scan_restart, ctl_cmd.scan_clear, idx_ff == SRC_W'(1) && found_ff == '0,
      "scan did not restart")

endmodule

### tb/interrupt_controller_two_context_tb.sv
`timescale 1ns / 1ps
module interrupt_controller_two_context_tb;

   localparam int          SOURCES       = ictc_pkg::SOURCES_DEF;
   localparam int          OFF_W         = ictc_pkg::OFF_W;
   localparam int          DATA_W        = ictc_pkg::DATA_W;
   localparam int          SRC_W         = ictc_pkg::SRC_W;
   localparam int          PRIO_W        = ictc_pkg::PRIO_W;
   localparam int          NUM_SLOTS     = ictc_pkg::NUM_SLOTS;
   localparam int          RANDOM_ITEMS  = 900;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          SETTLE_CYCLES = 80;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam logic [1:0]  CMD_NOP       = 2'd3;

   typedef struct packed {
      logic [1:0]        command;
      logic [OFF_W-1:0]  offset;
      logic              word;
      logic [DATA_W-1:0] wdata;
      logic [SRC_W-1:0]  src;
      logic              lvl;
   } request_type;

   typedef struct packed {
      logic [DATA_W-1:0] rdata;
      logic              err;
      logic              mirq;
      logic              sirq;
   } response_type;

   typedef struct packed {
      request_type  req;
      logic         typed;
      response_type rsp;
   } vector_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_command = '0;
   logic [OFF_W-1:0]    req_offset = '0;
   logic                req_word_access = 1'b0;
   logic [DATA_W-1:0]   req_write_data = '0;
   logic [SRC_W-1:0]    req_source_id = '0;
   logic                req_source_level = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DATA_W-1:0]   rsp_read_data;
   logic                rsp_access_error;
   logic                rsp_machine_irq;
   logic                rsp_supervisor_irq;

   // controller state as the testbench sees it
   logic [PRIO_W-1:0]   prio_of [NUM_SLOTS] = '{default: '0};
   logic                pend_of [NUM_SLOTS] = '{default: 1'b0};
   logic                level_of [NUM_SLOTS] = '{default: 1'b0};
   ictc_pkg::owner_type owner_of [NUM_SLOTS] = '{default: ictc_pkg::OWNER_NONE};
   logic [DATA_W-1:0]   enable_of [2] = '{default: '0};
   logic [PRIO_W-1:0]   threshold_of [2] = '{default: '0};

   response_type        awaited_responses [$];
   vector_type          directed_vectors [$];
   response_type        head;
   int                  failures = 0;
   bit                  quiet = 1'b0;
   int                  hold_requests = 0;
   int                  holds_done = 0;
   int                  hold_left = 0;
   int unsigned         cycle_count = 0;

   interrupt_controller_two_context #(.SOURCES(SOURCES)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_offset         (req_offset),
      .req_word_access    (req_word_access),
      .req_write_data     (req_write_data),
      .req_source_id      (req_source_id),
      .req_source_level   (req_source_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_access_error   (rsp_access_error),
      .rsp_machine_irq    (rsp_machine_irq),
      .rsp_supervisor_irq (rsp_supervisor_irq)
   );

   always #6 clock = ~clock;

   function automatic ictc_pkg::owner_type ctx_owner(int ctx);
      return (ctx == 0) ? ictc_pkg::OWNER_M : ictc_pkg::OWNER_S;
   endfunction

   // highest priority wins, lowest ID on a tie
   function automatic logic [SRC_W-1:0] pick_winner(int ctx);
      logic [SRC_W-1:0] best;
      best = '0;
      for (int s = 1; s <= SOURCES; s++) begin
         if (pend_of[s] && owner_of[s] == ictc_pkg::OWNER_NONE && enable_of[ctx][s] &&
             prio_of[s] > threshold_of[ctx] &&
             (best == 0 || prio_of[s] > prio_of[best]))
            best = SRC_W'(s);
      end
      return best;
   endfunction

   function automatic response_type apply_request(request_type r);
      response_type     rsp;
      int               ctx;
      logic [SRC_W-1:0] won;
      rsp = '0;
      if (r.command == ictc_pkg::CMD_READ || r.command == ictc_pkg::CMD_WRITE) begin
         if (!r.word || r.offset[1:0] != 2'b00) begin
            rsp.err = 1'b1;
         end else if (r.offset >= 4 && r.offset < 4 * (SOURCES + 1)) begin
            if (r.command == ictc_pkg::CMD_READ) rsp.rdata = DATA_W'(prio_of[r.offset[6:2]]);
            else prio_of[r.offset[6:2]] = r.wdata[PRIO_W-1:0];
         end else if (r.command == ictc_pkg::CMD_READ) begin
            case (r.offset) inside
               ictc_pkg::PENDING_OFF: begin
                  for (int s = 1; s <= SOURCES; s++) rsp.rdata[s] = pend_of[s];
               end
               ictc_pkg::M_ENABLE_OFF, ictc_pkg::S_ENABLE_OFF: begin
                  rsp.rdata = enable_of[r.offset == ictc_pkg::S_ENABLE_OFF];
               end
               ictc_pkg::M_THRESH_OFF, ictc_pkg::S_THRESH_OFF: begin
                  rsp.rdata = DATA_W'(threshold_of[r.offset == ictc_pkg::S_THRESH_OFF]);
               end
               ictc_pkg::M_CLAIM_OFF, ictc_pkg::S_CLAIM_OFF: begin
                  ctx = (r.offset == ictc_pkg::S_CLAIM_OFF);
                  won = pick_winner(ctx);
                  if (won != 0) begin
                     pend_of[won] = 1'b0;
                     owner_of[won] = ctx_owner(ctx);
                  end
                  rsp.rdata = DATA_W'(won);
               end
               default: rsp.rdata = '0;
            endcase
         end else begin
            case (r.offset) inside
               ictc_pkg::M_ENABLE_OFF, ictc_pkg::S_ENABLE_OFF: begin
                  enable_of[r.offset == ictc_pkg::S_ENABLE_OFF] = r.wdata & ~32'd1;
               end
               ictc_pkg::M_THRESH_OFF, ictc_pkg::S_THRESH_OFF: begin
                  threshold_of[r.offset == ictc_pkg::S_THRESH_OFF] = r.wdata[PRIO_W-1:0];
               end
               ictc_pkg::M_CLAIM_OFF, ictc_pkg::S_CLAIM_OFF: begin
                  ctx = (r.offset == ictc_pkg::S_CLAIM_OFF);
                  // release only when this context owns the claim, then relatch
                  if (r.wdata > 0 && r.wdata <= SOURCES &&
                      owner_of[r.wdata[SRC_W-1:0]] == ctx_owner(ctx)) begin
                     owner_of[r.wdata[SRC_W-1:0]] = ictc_pkg::OWNER_NONE;
                     pend_of[r.wdata[SRC_W-1:0]] = level_of[r.wdata[SRC_W-1:0]];
                  end
               end
               default: ;
            endcase
         end
      end else if (r.command == ictc_pkg::CMD_LEVEL) begin
         if (r.src != 0 && r.src <= SOURCES) begin
            level_of[r.src] = r.lvl;
            if (r.lvl && owner_of[r.src] == ictc_pkg::OWNER_NONE) pend_of[r.src] = 1'b1;
         end
      end
      rsp.mirq = (pick_winner(0) != 0);
      rsp.sirq = (pick_winner(1) != 0);
      return rsp;
   endfunction

   // mostly well-formed register traffic; completions follow live ownership
   function automatic request_type random_request();
      request_type r;
      int          pick;
      int          ctx;
      int          owned [$];
      pick = $urandom_range(99);
      ctx = $urandom_range(1);
      r.command = $urandom_range(1) ? ictc_pkg::CMD_WRITE : ictc_pkg::CMD_READ;
      r.offset = OFF_W'($urandom);
      r.word = 1'b1;
      r.wdata = $urandom;
      r.src = SRC_W'($urandom);
      r.lvl = 1'($urandom);
      if (pick < 28) begin
         r.command = ictc_pkg::CMD_LEVEL;
         r.word = 1'($urandom);
      end else if (pick < 44) begin
         r.offset = OFF_W'(4 * $urandom_range(33));
      end else if (pick < 52) begin
         r.offset = ctx ? ictc_pkg::S_ENABLE_OFF : ictc_pkg::M_ENABLE_OFF;
         if ($urandom_range(3) == 0) r.wdata = '1;
      end else if (pick < 58) begin
         r.offset = ctx ? ictc_pkg::S_THRESH_OFF : ictc_pkg::M_THRESH_OFF;
         // keep thresholds mostly low so sources stay selectable
         if ($urandom_range(3) != 0) r.wdata = $urandom_range(2);
      end else if (pick < 73) begin
         r.command = ictc_pkg::CMD_READ;
         r.offset = ctx ? ictc_pkg::S_CLAIM_OFF : ictc_pkg::M_CLAIM_OFF;
      end else if (pick < 86) begin
         r.command = ictc_pkg::CMD_WRITE;
         r.offset = ctx ? ictc_pkg::S_CLAIM_OFF : ictc_pkg::M_CLAIM_OFF;
         for (int s = 1; s <= SOURCES; s++)
            if (owner_of[s] == ctx_owner(ctx)) owned.push_back(s);
         if (owned.size() != 0 && $urandom_range(4) != 0)
            r.wdata = owned[$urandom_range(owned.size() - 1)];
         else if ($urandom_range(1))
            r.wdata = $urandom_range(40);
      end else if (pick < 90) begin
         r.offset = ictc_pkg::PENDING_OFF;
      end else if (pick < 95) begin
         r.offset = ctx ? ictc_pkg::S_CLAIM_OFF : ictc_pkg::M_CLAIM_OFF;
         if ($urandom_range(1)) r.word = 1'b0;
         else r.offset[1:0] = 2'($urandom_range(1, 3));
      end else if (pick < 97) begin
         r.command = CMD_NOP;
      end else begin
         r.word = 1'($urandom);
      end
      return r;
   endfunction

   task automatic add_vector(logic [1:0] cmd, logic [OFF_W-1:0] off, logic w,
                             logic [DATA_W-1:0] d, logic [SRC_W-1:0] s, logic l,
                             logic typed = 1'b0, logic [DATA_W-1:0] rd = '0,
                             logic err = 1'b0);
      vector_type v;
      v.req = '{command: cmd, offset: off, word: w, wdata: d, src: s, lvl: l};
      v.typed = typed;
      v.rsp = '{rdata: rd, err: err, mirq: 1'b0, sirq: 1'b0};
      directed_vectors.push_back(v);
   endtask

   task automatic send_request(request_type r, logic typed, response_type typed_rsp);
      response_type predicted;
      if (!quiet && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= r.command;
      req_offset <= r.offset;
      req_word_access <= r.word;
      req_write_data <= r.wdata;
      req_source_id <= r.src;
      req_source_level <= r.lvl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_request(r);
      awaited_responses.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_responses.size() != 0);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("response beat with nothing awaited: read_data %h", rsp_read_data);
               failures++;
            end else begin
               head = awaited_responses.pop_front();
               if (rsp_read_data !== head.rdata) begin
                  $error("rsp_read_data: expected %h, actual %h", head.rdata, rsp_read_data);
                  failures++;
               end
               if (rsp_access_error !== head.err) begin
                  $error("rsp_access_error: expected %b, actual %b", head.err,
                         rsp_access_error);
                  failures++;
               end
               if (rsp_machine_irq !== head.mirq) begin
                  $error("rsp_machine_irq: expected %b, actual %b", head.mirq,
                         rsp_machine_irq);
                  failures++;
               end
               if (rsp_supervisor_irq !== head.sirq) begin
                  $error("rsp_supervisor_irq: expected %b, actual %b", head.sirq,
                         rsp_supervisor_irq);
                  failures++;
               end
            end
         end
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 33);
         end
      end
   end

   initial begin
      // read-only and error rows right after reset have obvious answers
      add_vector(ictc_pkg::CMD_READ, 22'h000004, 1'b1, '0, 5'd0, 1'b0, 1'b1, '0, 1'b0);
      add_vector(ictc_pkg::CMD_READ, 22'h000002, 1'b1, '0, 5'd0, 1'b0, 1'b1, '0, 1'b1);
      add_vector(ictc_pkg::CMD_WRITE, 22'h000004, 1'b0, '1, 5'd0, 1'b0, 1'b1, '0, 1'b1);
      add_vector(ictc_pkg::CMD_READ, ictc_pkg::PENDING_OFF, 1'b1, '0, 5'd0, 1'b0,
                 1'b1, '0, 1'b0);
      add_vector(ictc_pkg::CMD_WRITE, 22'h000004, 1'b1, '1, 5'd31, 1'b1);
      add_vector(ictc_pkg::CMD_WRITE, 22'h00007C, 1'b1, 32'd3, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_WRITE, ictc_pkg::M_ENABLE_OFF, 1'b1, '1, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_READ, ictc_pkg::M_ENABLE_OFF, 1'b1, '0, 5'd0, 1'b0,
                 1'b1, 32'hFFFF_FFFE, 1'b0);
      add_vector(ictc_pkg::CMD_WRITE, ictc_pkg::S_ENABLE_OFF, 1'b1, 32'h8000_0003,
                 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_LEVEL, 22'h000000, 1'b1, '0, 5'd0, 1'b1);
      add_vector(ictc_pkg::CMD_LEVEL, 22'h3FFFFF, 1'b0, '1, 5'd1, 1'b1);
      add_vector(ictc_pkg::CMD_LEVEL, 22'h000000, 1'b1, '0, 5'd31, 1'b1);
      add_vector(ictc_pkg::CMD_READ, ictc_pkg::PENDING_OFF, 1'b1, '0, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_WRITE, ictc_pkg::PENDING_OFF, 1'b1, '1, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_WRITE, ictc_pkg::S_THRESH_OFF, 1'b1, '1, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_READ, ictc_pkg::S_THRESH_OFF, 1'b1, '0, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_READ, ictc_pkg::S_CLAIM_OFF, 1'b1, '0, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_READ, ictc_pkg::M_CLAIM_OFF, 1'b1, '0, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_LEVEL, 22'h000000, 1'b1, '0, 5'd1, 1'b0);
      add_vector(ictc_pkg::CMD_LEVEL, 22'h000000, 1'b1, '0, 5'd1, 1'b1);
      add_vector(ictc_pkg::CMD_WRITE, ictc_pkg::S_CLAIM_OFF, 1'b1, 32'd1, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_WRITE, ictc_pkg::M_CLAIM_OFF, 1'b1, '1, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_WRITE, ictc_pkg::M_CLAIM_OFF, 1'b1, 32'd1, 5'd0, 1'b0);
      add_vector(CMD_NOP, 22'h3FFFFF, 1'b1, '1, 5'd1, 1'b0);
      add_vector(ictc_pkg::CMD_READ, 22'h3FFFFC, 1'b1, '0, 5'd0, 1'b0);
      add_vector(ictc_pkg::CMD_WRITE, 22'h000080, 1'b1, '1, 5'd0, 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_vectors[i])
         send_request(directed_vectors[i].req, directed_vectors[i].typed,
                      directed_vectors[i].rsp);
      drain_responses();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // receiver holds off while requests keep coming
         if (i == 0 || i == 450) hold_requests++;
         if (i == 300) drain_responses();
         quiet = (i >= 550 && i < 700);
         send_request(random_request(), 1'b0, '0);
      end
      quiet = 1'b0;
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/ictc_pkg.sv
hdl/ictc_ctl.sv
hdl/ictc_dp.sv
hdl/interrupt_controller_two_context.sv
tb/interrupt_controller_two_context_tb.sv
